// ===== src/trwa_pkg.sv =====
// trwa_pkg: shared types and constants of the triangular random-walk angle block
// used by trwa_isqrt, trwa_div and triangular_random_walk_angle_top

package trwa_pkg;

  localparam int unsigned AngleW    = 10;
  localparam int unsigned RangeW    = 9;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned RadW      = 36;
  localparam int unsigned RootW     = RadW / 2;
  localparam int unsigned DivNumW   = 25;
  localparam int unsigned DivDenW   = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [RangeW-1:0]  AngleLimit   = 9'd361;
  localparam logic [DivDenW-1:0] FullSweepDeg = 10'd720;
  localparam logic [RangeW-1:0]  SweepRst     = 9'd80;
  localparam logic [TimeW-1:0]   MaxTimeRst   = 16'd2000;

  localparam logic [CfgIdxW-1:0] CfgSweepRange = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxTime    = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_SPLIT,
    S_RAD,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_ANGLE,
    S_PROD,
    S_DUR_GO,
    S_DUR_WAIT,
    S_DLY_GO,
    S_DLY_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic            done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;

endpackage

// ===== src/trwa_isqrt.sv =====
// trwa_isqrt: digit-by-digit integer square root, one result bit per cycle
// depends on trwa_pkg

module trwa_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [trwa_pkg::RadW-1:0]   rad_i,
  output trwa_pkg::sqrt_rsp_t         rsp_o
);

  localparam int unsigned RemW = trwa_pkg::RootW + 1;
  localparam int unsigned CntW = $clog2(trwa_pkg::RootW);
  localparam logic [CntW-1:0] LastCnt = CntW'(trwa_pkg::RootW - 1);

  logic [trwa_pkg::RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]            rem_q, rem_d;
  logic [trwa_pkg::RootW-1:0] root_q, root_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  logic [RemW+1:0] rem_sh;
  logic [RemW+1:0] trial;

  always_comb begin
    rem_sh = {rem_q, rad_q[trwa_pkg::RadW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[trwa_pkg::RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = RemW'(rem_sh - trial);
        root_d = {root_q[trwa_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[RemW-1:0];
        root_d = {root_q[trwa_pkg::RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

// ===== src/trwa_div.sv =====
// trwa_div: restoring unsigned divider, one quotient bit per cycle
// depends on trwa_pkg

module trwa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trwa_pkg::div_req_t  req_i,
  output trwa_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned NumW = trwa_pkg::DivNumW;
  localparam int unsigned DenW = trwa_pkg::DivDenW;
  localparam int unsigned CntW = $clog2(NumW);
  localparam logic [CntW-1:0] LastCnt = CntW'(NumW - 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [DenW:0] rem_sh;

  always_comb begin
    rem_sh = {rem_q, quo_q[NumW-1]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DenW'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== src/triangular_random_walk_angle_top.sv =====
// triangular_random_walk_angle_top: top level of the random-walk angle sampler
// depends on trwa_pkg, trwa_isqrt and trwa_div

// one uniform Q0.16 sample per move picks a new angle from a triangular
// distribution peaked at the current angle, over the window current +/-
// sweep_range clamped to +/-361; the block also returns step count, direction,
// sweep duration and delay per step. after the input beat a move forms the
// window, the split product and the radicand, starts the bit-serial square
// root (18 root bits, one per cycle) and waits for its done, forms the angle
// and the product and starts the duration, makes two passes through the
// shared restoring divider (25 quotient bits then a done; duration by 720,
// then delay by step count) with a start state for the second pass, and
// loads the output register once it is free. the next sample is taken only
// after the sequencer is back in idle; a stalled result holds the sequencer
// in its last state. input stall is high for the whole move; a finished
// result sits in the output register, so the next sample is taken while it
// waits. config writes are always ready and must only be made while idle

module triangular_random_walk_angle_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [trwa_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [trwa_pkg::CfgDataW-1:0]     cfg_data_i,
  // sample input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [trwa_pkg::SampleW-1:0]      uniform_sample_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [trwa_pkg::AngleW-1:0] new_angle_o,
  output logic [trwa_pkg::RangeW-1:0]       step_count_o,
  output logic                              step_direction_up_o,
  output logic [trwa_pkg::TimeW-1:0]        duration_ms_o,
  output logic [6:0]                        delay_per_step_ms_o
);

  localparam int unsigned AW  = trwa_pkg::AngleW;
  localparam int unsigned XW  = AW + 2;          // headroom for window sums
  localparam int unsigned UwW = trwa_pkg::SampleW + AW;

  // state
  trwa_pkg::state_e state_q, state_d;

  // config registers
  logic [trwa_pkg::RangeW-1:0] sweep_q;
  logic [trwa_pkg::TimeW-1:0]  max_time_q;

  // walk state
  logic signed [AW-1:0] cur_q;

  // per-move working registers
  logic [trwa_pkg::SampleW-1:0] u_q;
  logic signed [AW-1:0]         mn_q, mx_q;
  logic [AW-1:0]                w_q, a_q, b_q;
  logic [UwW-1:0]               uw_q;
  logic                         lower_q;
  logic [trwa_pkg::RadW-1:0]    rad_q;
  logic signed [AW-1:0]         na_q;
  logic [trwa_pkg::RangeW-1:0]  steps_q;
  logic                         up_q;
  logic [trwa_pkg::DivNumW-1:0] prod_q;
  logic [trwa_pkg::TimeW-1:0]   dur_q;
  logic [6:0]                   dly_q;

  // output register
  logic                         out_vld_q;
  logic signed [AW-1:0]         o_angle_q;
  logic [trwa_pkg::RangeW-1:0]  o_steps_q;
  logic                         o_up_q;
  logic [trwa_pkg::TimeW-1:0]   o_dur_q;
  logic [6:0]                   o_dly_q;

  // handshakes
  logic in_beat, out_beat, cfg_beat, out_free;

  assign cfg_ready_o = 1'b1;
  assign cfg_beat    = cfg_valid_i & cfg_ready_o;
  assign in_beat     = in_valid_i & ~in_stall_o;
  assign out_beat    = out_vld_q & ~out_stall_i;
  assign out_free    = ~out_vld_q | ~out_stall_i;

  // square root unit and shared divider
  logic                 sqrt_start;
  trwa_pkg::sqrt_rsp_t  sqrt_rsp;
  trwa_pkg::div_req_t   div_req;
  trwa_pkg::div_rsp_t   div_rsp;

  trwa_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad_q),
    .rsp_o   (sqrt_rsp)
  );

  trwa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // window arithmetic: r saturated to the angle limit, ends clamped to +/-361
  logic [trwa_pkg::RangeW-1:0] r_sat;
  logic signed [XW-1:0]        c_x, r_x, lo_x, hi_x, lim_x, mn_x, mx_x;

  always_comb begin
    r_sat = (sweep_q > trwa_pkg::AngleLimit) ? trwa_pkg::AngleLimit : sweep_q;
    c_x   = XW'(cur_q);
    r_x   = $signed({{(XW-trwa_pkg::RangeW){1'b0}}, r_sat});
    lim_x = $signed({{(XW-trwa_pkg::RangeW){1'b0}}, trwa_pkg::AngleLimit});
    lo_x  = c_x - r_x;
    hi_x  = c_x + r_x;
    mn_x  = (lo_x < -lim_x) ? -lim_x : lo_x;
    mx_x  = (hi_x > lim_x) ? lim_x : hi_x;
  end

  // split test and radicand: (2^16 - u) * w is formed as w * 2^16 - u * w
  logic                 lower_c;
  logic [UwW-1:0]       t_c;
  logic [AW-1:0]        f_c;

  always_comb begin
    lower_c = uw_q < {a_q, {trwa_pkg::SampleW{1'b0}}};
    t_c     = lower_c ? uw_q : UwW'({w_q, {trwa_pkg::SampleW{1'b0}}} - uw_q);
    f_c     = lower_c ? a_q : b_q;
  end

  // angle from the root, rounded half up in the direction of each branch
  logic [trwa_pkg::RootW:0] s_rnd;
  logic signed [XW-1:0]     inc_x, cand_x, na_x, diff_x;

  always_comb begin
    s_rnd  = {1'b0, sqrt_rsp.root} + (lower_q ? (trwa_pkg::RootW+1)'(128)
                                              : (trwa_pkg::RootW+1)'(127));
    inc_x  = $signed({1'b0, s_rnd[trwa_pkg::RootW:8]});
    cand_x = lower_q ? (XW'(mn_q) + inc_x) : (XW'(mx_q) - inc_x);
    if (cand_x > XW'(mx_q)) begin
      na_x = XW'(mx_q);
    end else if (cand_x < XW'(mn_q)) begin
      na_x = XW'(mn_q);
    end else begin
      na_x = cand_x;
    end
    diff_x = na_x - XW'(cur_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      trwa_pkg::S_IDLE:      if (in_beat) state_d = trwa_pkg::S_WIN;
      trwa_pkg::S_WIN:       state_d = trwa_pkg::S_SPLIT;
      trwa_pkg::S_SPLIT:     state_d = trwa_pkg::S_RAD;
      trwa_pkg::S_RAD:       state_d = trwa_pkg::S_SQRT_GO;
      trwa_pkg::S_SQRT_GO:   state_d = trwa_pkg::S_SQRT_WAIT;
      trwa_pkg::S_SQRT_WAIT: if (sqrt_rsp.done) state_d = trwa_pkg::S_ANGLE;
      trwa_pkg::S_ANGLE:     state_d = trwa_pkg::S_PROD;
      trwa_pkg::S_PROD:      state_d = trwa_pkg::S_DUR_GO;
      trwa_pkg::S_DUR_GO:    state_d = trwa_pkg::S_DUR_WAIT;
      trwa_pkg::S_DUR_WAIT:  if (div_rsp.done) state_d = trwa_pkg::S_DLY_GO;
      trwa_pkg::S_DLY_GO:    state_d = trwa_pkg::S_DLY_WAIT;
      trwa_pkg::S_DLY_WAIT:  if (div_rsp.done) state_d = trwa_pkg::S_DONE;
      trwa_pkg::S_DONE:      if (out_free) state_d = trwa_pkg::S_IDLE;
      default:               state_d = trwa_pkg::S_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_stall_o       = 1'b1;
    sqrt_start       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = trwa_pkg::FullSweepDeg;
    case (state_q)
      trwa_pkg::S_IDLE:    in_stall_o = 1'b0;
      trwa_pkg::S_SQRT_GO: sqrt_start = 1'b1;
      trwa_pkg::S_DUR_GO:  div_req.start = 1'b1;
      trwa_pkg::S_DLY_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = trwa_pkg::DivNumW'(dur_q);
        div_req.divisor  = trwa_pkg::DivDenW'(steps_q);
      end
      trwa_pkg::S_DLY_WAIT: begin
        div_req.dividend = trwa_pkg::DivNumW'(dur_q);
        div_req.divisor  = trwa_pkg::DivDenW'(steps_q);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= trwa_pkg::S_IDLE;
      sweep_q    <= trwa_pkg::SweepRst;
      max_time_q <= trwa_pkg::MaxTimeRst;
      cur_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_beat) begin
        case (cfg_index_i)
          trwa_pkg::CfgSweepRange: sweep_q    <= cfg_data_i[trwa_pkg::RangeW-1:0];
          trwa_pkg::CfgMaxTime:    max_time_q <= cfg_data_i[trwa_pkg::TimeW-1:0];
          default: ;
        endcase
      end
      if (state_q == trwa_pkg::S_ANGLE) begin
        cur_q <= AW'(na_x);
      end
      if (state_q == trwa_pkg::S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_beat) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      trwa_pkg::S_IDLE: begin
        if (in_beat) u_q <= uniform_sample_i;
      end
      trwa_pkg::S_WIN: begin
        mn_q <= AW'(mn_x);
        mx_q <= AW'(mx_x);
        w_q  <= AW'(mx_x - mn_x);
        a_q  <= AW'(c_x - mn_x);
        b_q  <= AW'(mx_x - c_x);
      end
      trwa_pkg::S_SPLIT: uw_q <= {{AW{1'b0}}, u_q} * {{trwa_pkg::SampleW{1'b0}}, w_q};
      trwa_pkg::S_RAD: begin
        lower_q <= lower_c;
        rad_q   <= {{(trwa_pkg::RadW-UwW){1'b0}}, t_c} *
                   {{(trwa_pkg::RadW-AW){1'b0}}, f_c};
      end
      trwa_pkg::S_ANGLE: begin
        na_q    <= AW'(na_x);
        up_q    <= diff_x > 0;
        steps_q <= trwa_pkg::RangeW'((diff_x < 0) ? -diff_x : diff_x);
      end
      trwa_pkg::S_PROD: begin
        prod_q <= {{(trwa_pkg::DivNumW-trwa_pkg::TimeW){1'b0}}, max_time_q} *
                  {{(trwa_pkg::DivNumW-trwa_pkg::RangeW){1'b0}}, steps_q};
      end
      trwa_pkg::S_DUR_WAIT: begin
        if (div_rsp.done) dur_q <= div_rsp.quotient[trwa_pkg::TimeW-1:0];
      end
      trwa_pkg::S_DLY_WAIT: begin
        // no steps means no delay
        if (div_rsp.done) dly_q <= (steps_q == '0) ? 7'd0 : div_rsp.quotient[6:0];
      end
      trwa_pkg::S_DONE: begin
        if (out_free) begin
          o_angle_q <= na_q;
          o_steps_q <= steps_q;
          o_up_q    <= up_q;
          o_dur_q   <= dur_q;
          o_dly_q   <= dly_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o         = out_vld_q;
  assign new_angle_o         = o_angle_q;
  assign step_count_o        = o_steps_q;
  assign step_direction_up_o = o_up_q;
  assign duration_ms_o       = o_dur_q;
  assign delay_per_step_ms_o = o_dly_q;

endmodule

// ===== test/tb_triangular_random_walk_angle_top.sv =====
// tb_triangular_random_walk_angle_top: self-checking testbench for the random-walk angle sampler
// depends on trwa_pkg and triangular_random_walk_angle_top; predicts every move and checks it

module tb_triangular_random_walk_angle_top;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned ResetCycles   = 4;
  // longest quiet stretch of a correct run is the hold-off plus one move
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldOffCycles = 2500;
  localparam int unsigned DrainCycles   = 100;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned PhaseItems    = 150;
  localparam int unsigned PressureItems = 12;

  // register indexes with no register behind them
  localparam logic [trwa_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [trwa_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallToggle
  } stall_mode_e;

  typedef struct packed {
    logic signed [trwa_pkg::AngleW-1:0] new_angle;
    logic [trwa_pkg::RangeW-1:0]        step_count;
    logic                               step_direction_up;
    logic [trwa_pkg::TimeW-1:0]         duration_ms;
    logic [6:0]                         delay_per_step_ms;
  } move_t;

  // all block inputs known from time zero
  logic                               clk_i            = 1'b0;
  logic                               rst_ni           = 1'b0;
  logic                               cfg_valid_i      = 1'b0;
  logic                               cfg_ready_o;
  logic [trwa_pkg::CfgIdxW-1:0]       cfg_index_i      = trwa_pkg::CfgSweepRange;
  logic [trwa_pkg::CfgDataW-1:0]      cfg_data_i       = '0;
  logic                               in_valid_i       = 1'b0;
  logic                               in_stall_o;
  logic [trwa_pkg::SampleW-1:0]       uniform_sample_i = '0;
  logic                               out_valid_o;
  logic                               out_stall_i      = 1'b0;
  logic signed [trwa_pkg::AngleW-1:0] new_angle_o;
  logic [trwa_pkg::RangeW-1:0]        step_count_o;
  logic                               step_direction_up_o;
  logic [trwa_pkg::TimeW-1:0]         duration_ms_o;
  logic [6:0]                         delay_per_step_ms_o;

  // predictor state: register copies and the walk position
  logic [trwa_pkg::RangeW-1:0]        model_range    = trwa_pkg::SweepRst;
  logic [trwa_pkg::TimeW-1:0]         model_max_time = trwa_pkg::MaxTimeRst;
  logic signed [trwa_pkg::AngleW-1:0] walk_angle     = '0;

  move_t       pending_moves[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned moves_checked  = 0;
  int unsigned regs_written   = 0;

  // sender burst control
  bit          sender_gaps = 1'b1;
  int unsigned burst_left  = 0;

  // receiver hold-off handshake between the test sequence and the receiver process
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned pattern_left  = 0;
  stall_mode_e stall_mode    = StallNone;

  int unsigned idle_cycles = 0;

  triangular_random_walk_angle_top i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .uniform_sample_i    (uniform_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .new_angle_o         (new_angle_o),
    .step_count_o        (step_count_o),
    .step_direction_up_o (step_direction_up_o),
    .duration_ms_o       (duration_ms_o),
    .delay_per_step_ms_o (delay_per_step_ms_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // floor of the square root, built one root bit at a time from the top
  function automatic longint floor_root(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int k = trwa_pkg::RootW - 1; k >= 0; k--) begin
      trial = root | (longint'(1) << k);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // next angle of the walk plus the sweep figures, from the current predictor state
  function automatic move_t predict_move(input logic [trwa_pkg::SampleW-1:0] u);
    move_t  m;
    longint lim, r, c, lo, hi, w, a, b, uu, s, na, steps, dur;
    lim = longint'(trwa_pkg::AngleLimit);
    r   = (model_range > trwa_pkg::AngleLimit) ? lim : longint'(model_range);
    c   = longint'(walk_angle);
    lo  = c - r;
    hi  = c + r;
    if (lo < -lim) lo = -lim;
    if (hi > lim) hi = lim;
    if (hi <= lo) begin
      // empty window, the angle stays put
      na = c;
    end else begin
      w  = hi - lo;
      a  = c - lo;
      b  = hi - c;
      uu = longint'(u);
      if (uu * w < a * 65536) begin
        // rising flank of the triangle, rounded half up
        s  = floor_root(uu * w * a);
        na = lo + ((s + 128) >>> 8);
      end else begin
        // falling flank, measured down from the top of the window
        s  = floor_root((65536 - uu) * w * b);
        na = hi - ((s + 127) >>> 8);
      end
      if (na > hi) na = hi;
      if (na < lo) na = lo;
    end
    steps = (na > c) ? na - c : c - na;
    dur   = (longint'(model_max_time) * steps) / longint'(trwa_pkg::FullSweepDeg);
    m.new_angle         = trwa_pkg::AngleW'(na);
    m.step_count        = trwa_pkg::RangeW'(steps);
    m.step_direction_up = (na > c);
    m.duration_ms       = trwa_pkg::TimeW'(dur);
    m.delay_per_step_ms = 7'((steps > 0) ? dur / steps : 0);
    return m;
  endfunction

  function automatic logic [trwa_pkg::SampleW-1:0] pick_sample();
    logic [trwa_pkg::SampleW-1:0] u;
    case ($urandom_range(0, 9))
      0:       u = '0;
      1:       u = '1;
      2:       u = trwa_pkg::SampleW'($urandom_range(0, 255));
      3:       u = 16'hFFFF - trwa_pkg::SampleW'($urandom_range(0, 255));
      default: u = trwa_pkg::SampleW'($urandom);
    endcase
    return u;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // one config beat; one quiet cycle afterwards keeps valid from bouncing in a step
  task automatic write_reg(input logic [trwa_pkg::CfgIdxW-1:0] idx,
                           input logic [trwa_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == trwa_pkg::CfgSweepRange) model_range = data[trwa_pkg::RangeW-1:0];
    else if (idx == trwa_pkg::CfgMaxTime) model_max_time = data;
    regs_written++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one sample beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_sample(input logic [trwa_pkg::SampleW-1:0] u);
    move_t       m;
    int unsigned gap;
    in_valid_i       <= 1'b1;
    uniform_sample_i <= u;
    do @(posedge clk_i); while (in_stall_o);
    m = predict_move(u);
    walk_angle = m.new_angle;
    pending_moves.push_back(m);
    items_sent++;
    if (sender_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 6);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // block idle: no sample offered and every predicted move delivered
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    logic [trwa_pkg::SampleW-1:0] picks[7] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                                               16'hFFFE, 16'h5555, 16'hAAAA};
    foreach (picks[k]) send_sample(picks[k]);
  endtask

  task automatic test_window_extremes();
    logic [trwa_pkg::SampleW-1:0] picks[6] = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                                               16'hFFFF, 16'h8000};
    wait_idle();
    write_reg(trwa_pkg::CfgSweepRange, trwa_pkg::CfgDataW'(trwa_pkg::AngleLimit));
    write_reg(trwa_pkg::CfgMaxTime, 16'hFFFF);
    // a zero sample drops to the floor, from there only the falling flank is left
    foreach (picks[k]) send_sample(picks[k]);
  endtask

  task automatic test_range_saturation();
    wait_idle();
    // widest register value, saturated to the angle limit
    write_reg(trwa_pkg::CfgSweepRange, 16'h01FF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h4000);
    wait_idle();
    // upper data bits do not reach the 9-bit register
    write_reg(trwa_pkg::CfgSweepRange, 16'hFE05);
    send_sample(16'hC000);
  endtask

  task automatic test_zero_range_and_time();
    wait_idle();
    write_reg(trwa_pkg::CfgSweepRange, 16'h0000);
    send_sample(16'h1234);
    send_sample(16'hFFFF);
    wait_idle();
    write_reg(trwa_pkg::CfgSweepRange, 16'd40);
    write_reg(trwa_pkg::CfgMaxTime, 16'h0000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    wait_idle();
    // writes to spare indexes must leave both registers alone
    write_reg(CfgSpareA, trwa_pkg::CfgDataW'($urandom));
    write_reg(CfgSpareB, trwa_pkg::CfgDataW'($urandom));
    send_sample(16'h7FFF);
  endtask

  task automatic test_random_walk();
    logic [trwa_pkg::RangeW-1:0] range;
    logic [trwa_pkg::TimeW-1:0]  max_time;
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin range = 9'd1;                max_time = 16'hFFFF;          end
        1: begin range = trwa_pkg::AngleLimit; max_time = 16'h0000;         end
        2: begin range = trwa_pkg::AngleLimit; max_time = 16'hFFFF;         end
        3: begin range = trwa_pkg::RangeW'($urandom_range(362, 511));
                 max_time = trwa_pkg::TimeW'($urandom);                     end
        4: begin range = trwa_pkg::RangeW'($urandom_range(1, 40));
                 max_time = trwa_pkg::TimeW'($urandom);                     end
        default: begin range = trwa_pkg::RangeW'($urandom_range(1, 361));
                       max_time = trwa_pkg::TimeW'($urandom);               end
      endcase
      wait_idle();
      write_reg(trwa_pkg::CfgSweepRange, {7'($urandom), range});
      write_reg(trwa_pkg::CfgMaxTime, max_time);
      repeat (PhaseItems) send_sample(pick_sample());
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(trwa_pkg::CfgSweepRange, 16'd120);
    write_reg(trwa_pkg::CfgMaxTime, 16'd3000);
    // receiver holds off while samples keep coming back to back
    sender_gaps = 1'b0;
    hold_requests++;
    repeat (PressureItems) send_sample(pick_sample());
    sender_gaps = 1'b1;
  endtask

  // main sequence
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_window_extremes();
    test_range_saturation();
    test_zero_range_and_time();
    test_random_walk();
    test_backpressure();

    // drain, then give the block time to show any stray beat
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_moves.size() != 0) begin
      report_mismatch($sformatf("%0d moves never delivered", pending_moves.size()));
    end

    $display("summary: %0d samples, %0d moves checked, %0d register writes", items_sent,
             moves_checked, regs_written);
    $display({"covered: reset values, full and saturated windows, zero range, zero time, ",
              "spare indexes, random walk and receiver hold-off"});
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result checker: every output beat against the oldest predicted move
  always @(posedge clk_i) begin
    move_t got;
    move_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.new_angle         = new_angle_o;
      got.step_count        = step_count_o;
      got.step_direction_up = step_direction_up_o;
      got.duration_ms       = duration_ms_o;
      got.delay_per_step_ms = delay_per_step_ms_o;
      if (pending_moves.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, angle %0d",
                                  got.new_angle));
      end else begin
        want = pending_moves.pop_front();
        if (got.new_angle !== want.new_angle)
          report_mismatch($sformatf("move %0d new_angle %0d, want %0d", moves_checked,
                                    got.new_angle, want.new_angle));
        if (got.step_count !== want.step_count)
          report_mismatch($sformatf("move %0d step_count %0d, want %0d", moves_checked,
                                    got.step_count, want.step_count));
        if (got.step_direction_up !== want.step_direction_up)
          report_mismatch($sformatf("move %0d step_direction_up %0d, want %0d",
                                    moves_checked, got.step_direction_up,
                                    want.step_direction_up));
        if (got.duration_ms !== want.duration_ms)
          report_mismatch($sformatf("move %0d duration_ms %0d, want %0d", moves_checked,
                                    got.duration_ms, want.duration_ms));
        if (got.delay_per_step_ms !== want.delay_per_step_ms)
          report_mismatch($sformatf("move %0d delay_per_step_ms %0d, want %0d",
                                    moves_checked, got.delay_per_step_ms,
                                    want.delay_per_step_ms));
      end
      moves_checked++;
    end
  end

  // receiver: random stall pattern in stretches, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldOffCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        stall_mode   = stall_mode_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 400);
      end
      pattern_left--;
      case (stall_mode)
        StallNone:  out_stall_i <= 1'b0;
        StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
        StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:    out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // watchdog: too long without any beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d moves pending", idle_cycles,
               pending_moves.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
